>>> design/assert_macros.svh
// Assertion macros shared by the checker files of the address pool allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is low.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_RST_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/ipa_pkg.sv
// Shared constants, types and encoder functions for the address pool allocator.
package ipa_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = POOL_DEPTH / WORD_W;
    localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int SLOT_W     = WIDX_W + BIT_W;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = ((ADDR_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ADDR_W + CNT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - ADDR_W - CNT_W;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 1'd1;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_OUTSIDE   = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    typedef struct packed {
        logic              rd_en;
        logic [WIDX_W-1:0] rd_idx;
        logic              wr_en;
        logic [WIDX_W-1:0] wr_idx;
        logic [WORD_W-1:0] wr_data;
    } mem_req_t;

    function automatic logic [BIT_W-1:0] first_one_word(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [WIDX_W-1:0] first_one_summary(input logic [NUM_WORDS-1:0] v);
        logic [WIDX_W-1:0] r;
        r = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = WIDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> design/ipa_bitmap_mem.sv
// Free bitmap word memory with per-word valid bits; unwritten words read as all free.
module ipa_bitmap_mem (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ipa_pkg::mem_req_t               req,
    output logic [ipa_pkg::WORD_W-1:0]      rd_word
);
    import ipa_pkg::*;

    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] valid_reg;
    logic [NUM_WORDS-1:0] valid_next;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (req.wr_en) begin
            valid_next[req.wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_idx] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg  <= mem[req.rd_idx];
            rd_valid_reg <= valid_reg[req.rd_idx];
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : '1;

endmodule

>>> design/ip_address_pool_allocator.sv
// Top level of the IPv4 address pool allocator: request sequencer, counters and output beat.
//
// Requests arrive on the s_ channel: s_tuser is the action (0 allocate, 1 release)
// and s_tdata the address to release. Each request yields exactly one result beat
// on the m_ channel: m_tuser is the status, m_tdata holds the granted address and
// the in-use count. pool_base and pool_size are written through cfg_wr_en,
// cfg_addr and cfg_wr_data; the user must write them only while no request is in
// flight, and the block itself does not enforce this.
// The free bitmap sits in a word memory with a registered read; a summary
// register flags words that still hold a free slot. Each request passes through
// accept, range or count check with word select and memory read, then
// read-modify-write with the result loaded into the output register. A new
// request can be taken in the cycle after the previous result is loaded, not before.
// If the output register is still full, the block holds the modified word and the
// result until the pending beat is taken; s_tready stays low meanwhile.
// Reset empties the pool at once (every slot free, count zero), sets pool_base to
// zero and pool_size to 1024, and drops any pending beat.
module ip_address_pool_allocator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ipa_pkg::IN_DATA_W-1:0]       s_tdata,   // [31:0] address
    input  logic                                s_tuser,   // [0] action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ipa_pkg::OUT_DATA_W-1:0]      m_tdata,   // [31:0] granted_address,
                                                           // [42:32] in_use_count, rest 0
    output logic [1:0]                          m_tuser,   // [1:0] status
    input  logic                                cfg_wr_en,
    input  logic [ipa_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [ipa_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import ipa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_MOD  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic                 action_reg, action_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_WORDS-1:0] summary_reg, summary_next;
    logic [WIDX_W-1:0]    widx_reg, widx_next;
    logic [BIT_W-1:0]     bidx_reg, bidx_next;
    logic                 ok_reg, ok_next;
    logic                 m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]    granted_reg, granted_next;
    status_t              status_reg, status_next;
    logic [CNT_W-1:0]     out_count_reg, out_count_next;

    mem_req_t             mem_req;
    logic [WORD_W-1:0]    rd_word;

    logic [ADDR_W-1:0]    offset;
    logic [31:0]          size_eff;
    logic                 in_range;
    logic                 alloc_ok;
    logic                 go;
    logic [BIT_W-1:0]     free_bit;
    logic [BIT_W-1:0]     sel_bit;
    logic [WORD_W-1:0]    new_word;
    logic                 hit_free;

    ipa_bitmap_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_word (rd_word)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {OUT_PAD_W'(0), out_count_reg, granted_reg};

    always_comb begin
        offset   = addr_reg - base_reg;
        size_eff = (32'(size_reg) < 32'(POOL_DEPTH)) ? 32'(size_reg) : 32'(POOL_DEPTH);
        in_range = 32'(offset) < size_eff;
        alloc_ok = 32'(count_reg) < size_eff;
        go       = !m_valid_reg || m_tready;
        free_bit = first_one_word(rd_word);
        sel_bit  = (action_reg == ACT_ALLOC) ? free_bit : bidx_reg;
        hit_free = rd_word[bidx_reg];
        new_word = rd_word;
        new_word[sel_bit] = (action_reg == ACT_RELEASE);
    end

    always_comb begin
        state_next     = state_reg;
        action_next    = action_reg;
        addr_next      = addr_reg;
        base_next      = base_reg;
        size_next      = size_reg;
        count_next     = count_reg;
        summary_next   = summary_reg;
        widx_next      = widx_reg;
        bidx_next      = bidx_reg;
        ok_next        = ok_reg;
        m_valid_next   = m_valid_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        out_count_next = out_count_reg;

        mem_req         = '0;
        mem_req.rd_idx  = widx_next;
        mem_req.wr_idx  = widx_reg;
        mem_req.wr_data = new_word;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_POOL_BASE: base_next = cfg_wr_data[ADDR_W-1:0];
                REG_POOL_SIZE: size_next = cfg_wr_data[SIZE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    action_next = s_tuser;
                    addr_next   = s_tdata[ADDR_W-1:0];
                    state_next  = S_LOOK;
                end
            end
            S_LOOK: begin
                if (action_reg == ACT_ALLOC) begin
                    widx_next = first_one_summary(summary_reg);
                    ok_next   = alloc_ok;
                end else begin
                    widx_next = offset[SLOT_W-1:BIT_W];
                    ok_next   = in_range;
                end
                bidx_next      = offset[BIT_W-1:0];
                mem_req.rd_en  = ok_next;
                mem_req.rd_idx = widx_next;
                state_next     = S_MOD;
            end
            S_MOD: begin
                if (go) begin
                    m_valid_next = 1'b1;
                    granted_next = '0;
                    if (action_reg == ACT_ALLOC) begin
                        if (ok_reg) begin
                            status_next   = ST_OK;
                            granted_next  = base_reg + ADDR_W'({widx_reg, free_bit});
                            count_next    = count_reg + CNT_W'(1);
                            mem_req.wr_en = 1'b1;
                            summary_next[widx_reg] = |new_word;
                        end else begin
                            status_next = ST_EXHAUSTED;
                        end
                    end else begin
                        if (!ok_reg) begin
                            status_next = ST_OUTSIDE;
                        end else if (hit_free) begin
                            status_next = ST_NOT_ALLOC;
                        end else begin
                            status_next   = ST_OK;
                            mem_req.wr_en = 1'b1;
                            summary_next[widx_reg] = 1'b1;
                            if (count_reg != '0) begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                    out_count_next = count_next;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            base_reg    <= '0;
            size_reg    <= SIZE_W'(1024);
            count_reg   <= '0;
            summary_reg <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            size_reg    <= size_next;
            count_reg   <= count_next;
            summary_reg <= summary_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg    <= action_next;
        addr_reg      <= addr_next;
        widx_reg      <= widx_next;
        bidx_reg      <= bidx_next;
        ok_reg        <= ok_next;
        granted_reg   <= granted_next;
        status_reg    <= status_next;
        out_count_reg <= out_count_next;
    end

endmodule

>>> design/ipa_checker.sv
// Port-level checker for the address pool allocator, bound to the top level.
`include "assert_macros.svh"

module ipa_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [ipa_pkg::OUT_DATA_W-1:0]      m_tdata,
    input logic [1:0]                          m_tuser
);
    import ipa_pkg::*;

    `ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    `ASSERT_IMP(a_fail_no_grant, m_tvalid && (m_tuser != ST_OK), m_tdata[ADDR_W-1:0] == '0)

    `ASSERT_IMP(a_count_bound, m_tvalid, m_tdata[ADDR_W +: CNT_W] <= CNT_W'(POOL_DEPTH))

    `ASSERT_RST_NXT(a_reset_idle, !aresetn, !m_tvalid)

endmodule

bind ip_address_pool_allocator ipa_checker u_ipa_checker (.*);

>>> verif/ip_address_pool_allocator_tb.sv
// Self-checking testbench for the IPv4 address pool allocator: stream driver, monitor, predictor.
module ip_address_pool_allocator_tb;
    import ipa_pkg::*;

    typedef struct packed {
        logic              act;
        logic [ADDR_W-1:0] addr;
    } pool_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] grant;
        status_t           status;
        logic [CNT_W-1:0]  count;
    } pool_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = ACT_ALLOC;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = REG_POOL_BASE;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    ip_address_pool_allocator uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state
    bit               pool_free [POOL_DEPTH];
    int               pool_used;
    logic [ADDR_W-1:0] cfg_base;
    logic [SIZE_W-1:0] cfg_size;

    pool_req_t    req_q[$];
    pool_result_t grant_q[$];
    pool_result_t want;
    pool_req_t    nxt;

    bit no_idle;
    int send_gap;
    int recv_gap;
    int errors;
    int reqs_sent;
    int results_seen;
    int phases;
    int status_seen [4];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 75) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int eff_size();
        return (int'(cfg_size) < POOL_DEPTH) ? int'(cfg_size) : POOL_DEPTH;
    endfunction

    function automatic pool_result_t pool_predict(input logic act, input logic [ADDR_W-1:0] addr);
        pool_result_t r;
        int eff;
        int slot;
        logic [ADDR_W-1:0] off;
        r.grant  = '0;
        r.status = ST_OK;
        eff = eff_size();
        if (act == ACT_ALLOC) begin
            slot = -1;
            if (pool_used < eff) begin
                for (int i = eff - 1; i >= 0; i--) begin
                    if (pool_free[i]) slot = i;
                end
            end
            if (slot >= 0) begin
                pool_free[slot] = 1'b0;
                pool_used++;
                r.grant = cfg_base + ADDR_W'(slot);
            end else begin
                r.status = ST_EXHAUSTED;
            end
        end else begin
            off = addr - cfg_base;
            if (off >= ADDR_W'(eff)) begin
                r.status = ST_OUTSIDE;
            end else if (pool_free[off[9:0]]) begin
                r.status = ST_NOT_ALLOC;
            end else begin
                pool_free[off[9:0]] = 1'b1;
                if (pool_used > 0) pool_used--;
            end
        end
        r.count = CNT_W'(pool_used);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_release(input int eff);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && eff > 0) return cfg_base + ADDR_W'($urandom_range(0, eff - 1));
        if (r < 80) return cfg_base + ADDR_W'(eff) + ADDR_W'($urandom_range(0, 2));
        if (r < 88) return cfg_base - ADDR_W'($urandom_range(1, 2));
        return $urandom;
    endfunction

    // sender: hold each beat until accepted, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                grant_q.push_back(pool_predict(s_tuser, s_tdata[ADDR_W-1:0]));
                reqs_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    nxt = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.act;
                    s_tdata  <= nxt.addr;
                    send_gap = idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: compare each beat with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                status_seen[m_tuser]++;
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%0d", $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = grant_q.pop_front();
                    if (m_tdata[ADDR_W-1:0] !== want.grant) begin
                        $display("%0t: granted_address expected %h actual %h",
                                 $time, want.grant, m_tdata[ADDR_W-1:0]);
                        errors++;
                    end
                    if (m_tuser !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[ADDR_W+CNT_W-1:ADDR_W] !== want.count) begin
                        $display("%0t: in_use_count expected %0d actual %0d",
                                 $time, want.count, m_tdata[ADDR_W+CNT_W-1:ADDR_W]);
                        errors++;
                    end
                    if (m_tdata[OUT_DATA_W-1:ADDR_W+CNT_W] !== '0) begin
                        $display("%0t: tdata padding expected 0 actual %h",
                                 $time, m_tdata[OUT_DATA_W-1:ADDR_W+CNT_W]);
                        errors++;
                    end
                end
                if (results_seen == 400 || results_seen == 1300) recv_gap = 150;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                recv_gap = idle_len();
                m_tready <= (recv_gap == 0);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        if (idx == REG_POOL_BASE) cfg_base = val;
        else cfg_size = val[SIZE_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_req(input logic act, input logic [ADDR_W-1:0] addr);
        pool_req_t r;
        r.act  = act;
        r.addr = addr;
        req_q.push_back(r);
    endtask

    task automatic wait_idle(input int limit);
        int n;
        n = 0;
        @(negedge aclk);
        while ((req_q.size() != 0 || s_tvalid || grant_q.size() != 0) && n < limit) begin
            @(negedge aclk);
            n++;
        end
        if (grant_q.size() != 0 || req_q.size() != 0) begin
            $display("%0t: %0d results missing", $time, grant_q.size());
            errors++;
            grant_q.delete();
        end
        repeat (6) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [CFG_DATA_W-1:0] size,
                             input int n, input int alloc_pct, input bit calm);
        int eff;
        write_reg(REG_POOL_BASE, base);
        write_reg(REG_POOL_SIZE, size);
        no_idle = calm;
        phases++;
        eff = eff_size();
        @(negedge aclk);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < alloc_pct) push_req(ACT_ALLOC, $urandom);
            else push_req(ACT_RELEASE, pick_release(eff));
        end
        wait_idle(200000);
    endtask

    initial begin
        for (int i = 0; i < POOL_DEPTH; i++) pool_free[i] = 1'b1;
        pool_used = 0;
        cfg_base  = '0;
        cfg_size  = SIZE_W'(POOL_DEPTH);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        phases = 1;

        // reset settings: grant order, double release, range edges
        @(negedge aclk);
        push_req(ACT_ALLOC, 32'h0000_0000);
        push_req(ACT_ALLOC, 32'hFFFF_FFFF);
        push_req(ACT_RELEASE, 32'd0);
        push_req(ACT_RELEASE, 32'd0);
        push_req(ACT_RELEASE, 32'd1024);
        push_req(ACT_RELEASE, 32'd1023);
        push_req(ACT_ALLOC, 32'h5555_AAAA);
        push_req(ACT_RELEASE, 32'hFFFF_FFFF);
        push_req(ACT_RELEASE, 32'd1);
        push_req(ACT_RELEASE, 32'd0);
        wait_idle(20000);

        // pool across the top of the address space, then full
        write_reg(REG_POOL_BASE, 32'hFFFF_FFFE);
        write_reg(REG_POOL_SIZE, 32'd4);
        phases++;
        @(negedge aclk);
        repeat (5) push_req(ACT_ALLOC, $urandom);
        push_req(ACT_RELEASE, 32'h0000_0000);
        push_req(ACT_RELEASE, 32'hFFFF_FFFD);
        push_req(ACT_RELEASE, 32'h0000_0002);
        wait_idle(20000);

        // shrink while slots beyond the new size stay allocated
        write_reg(REG_POOL_SIZE, 32'd2);
        phases++;
        @(negedge aclk);
        push_req(ACT_ALLOC, 32'd0);
        push_req(ACT_RELEASE, 32'h0000_0001);
        push_req(ACT_RELEASE, 32'hFFFF_FFFF);
        push_req(ACT_ALLOC, 32'd0);
        wait_idle(20000);

        // empty pool
        write_reg(REG_POOL_SIZE, 32'd0);
        phases++;
        @(negedge aclk);
        push_req(ACT_ALLOC, 32'd0);
        push_req(ACT_RELEASE, 32'hFFFF_FFFE);
        wait_idle(20000);

        run_phase($urandom, 32'd1, 60, 50, 1'b0);
        run_phase(32'hFFFF_FFF0, 32'd37, 120, 60, 1'b0);
        run_phase($urandom, 32'd8, 100, 55, 1'b1);
        // fill to the bitmap depth; upper write data bits are don't-care
        run_phase(32'hFFFF_FF00, 32'hFFFF_F7FF, 1060, 99, 1'b0);
        run_phase(32'h0A00_0000, 32'd1024, 200, 30, 1'b0);
        run_phase($urandom, 32'd100, 120, 55, 1'b1);
        run_phase(32'hFFFF_FFFF, 32'd0, 10, 50, 1'b0);

        repeat (20) @(posedge aclk);
        $display("Sent %0d requests over %0d pool settings, checked %0d results",
                 reqs_sent, phases, results_seen);
        $display("Status mix: ok %0d, exhausted %0d, outside %0d, not allocated %0d",
                 status_seen[ST_OK], status_seen[ST_EXHAUSTED],
                 status_seen[ST_OUTSIDE], status_seen[ST_NOT_ALLOC]);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
